>>> hdl/owtp_pkg.sv
// Shared types and constants for the owned stopwatch timer pool.
`timescale 1ns / 1ps
`default_nettype none

package owtp_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int OWNER_BITS_DEF = 8;

  localparam int TIME_W   = 31;
  localparam int MODE_W   = 3;
  localparam int HANDLE_W = 8;
  localparam int OWNER_W  = 8;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DENIED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

endpackage

`default_nettype wire

>>> hdl/owned_stopwatch_timer_pool_top.sv
// Flow: an accepted request word is registered together with its slot memory read, and the
// execute state then registers the result word and the slot memory write back.
// A new request is taken only after the previous one has left the execute state,
// and a stalled result holds off the next request.
// Reset: clears the uptime counter, the per-slot allocation flags and the handshake state.
// The slot memory itself is not cleared; create initializes a slot before it can be used.
`timescale 1ns / 1ps
`default_nettype none

module owned_stopwatch_timer_pool_top #(
  parameter int SLOTS      = owtp_pkg::SLOTS_DEF,
  parameter int OWNER_BITS = owtp_pkg::OWNER_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0: mode[2:0], handle[10:3], owner_id[18:11], zero fill.
  input  wire logic [owtp_pkg::IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: has_capability[0].
  input  wire logic [0:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // Fields from bit 0: value[30:0], zero fill.
  output logic [owtp_pkg::OUT_DATA_W-1:0]      m_tdata,
  // Fields from bit 0: status[1:0].
  output logic [owtp_pkg::STATUS_W-1:0]        m_tuser
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [owtp_pkg::HANDLE_W:0] HANDLE_LIM = (owtp_pkg::HANDLE_W + 1)'(SLOTS);

  typedef struct packed {
    logic                        running;
    logic [owtp_pkg::TIME_W-1:0] start;
    logic [owtp_pkg::TIME_W-1:0] elapsed;
    logic [OWNER_BITS-1:0]       owner;
  } slot_entry_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Request fields held for the execute cycle.
  logic [owtp_pkg::MODE_W-1:0]   mode_q;
  logic [owtp_pkg::HANDLE_W-1:0] handle_q;
  logic [OWNER_BITS-1:0]         owner_q;
  logic                          cap_q;

  logic [owtp_pkg::TIME_W-1:0]   uptime;
  logic [SLOTS-1:0]              alloc;
  logic [owtp_pkg::TIME_W-1:0]   value_q;
  logic [owtp_pkg::STATUS_W-1:0] status_q;

  slot_entry_t mem [SLOTS];
  slot_entry_t rd_q;

  logic              accept;
  logic [IDX_W-1:0]  rd_addr;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign rd_addr  = s_tdata[owtp_pkg::MODE_W +: IDX_W];

  assign m_tdata = {{(owtp_pkg::OUT_DATA_W - owtp_pkg::TIME_W){1'b0}}, value_q};
  assign m_tuser = status_q;

  // Execute cycle: decode, check and build the write back.
  logic [IDX_W-1:0]              idx;
  logic                          in_range;
  logic                          free_found;
  logic [IDX_W-1:0]              free_idx;
  logic [owtp_pkg::TIME_W-1:0]   live_elapsed;
  logic [owtp_pkg::STATUS_W-1:0] status_next;
  logic [owtp_pkg::TIME_W-1:0]   value_next;
  logic                          tick;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  slot_entry_t                   wr_data;
  logic                          alloc_set;
  logic                          alloc_clr;

  assign idx          = handle_q[IDX_W-1:0];
  assign in_range     = {1'b0, handle_q} < HANDLE_LIM;
  assign live_elapsed = uptime - rd_q.start;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!alloc[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    logic chk_ok;
    logic [owtp_pkg::STATUS_W-1:0] chk_status;

    status_next = owtp_pkg::ST_OK;
    value_next  = '0;
    tick        = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx;
    wr_data     = rd_q;
    alloc_set   = 1'b0;
    alloc_clr   = 1'b0;

    // Handle range, then allocation, then owner.
    if (!in_range || !alloc[idx]) begin
      chk_status = owtp_pkg::ST_INVALID;
    end else if (rd_q.owner != owner_q) begin
      chk_status = owtp_pkg::ST_DENIED;
    end else begin
      chk_status = owtp_pkg::ST_OK;
    end
    chk_ok = (chk_status == owtp_pkg::ST_OK);

    case (mode_q)
      owtp_pkg::MODE_TICK: begin
        tick = 1'b1;
      end
      owtp_pkg::MODE_CREATE: begin
        if (!cap_q) begin
          status_next = owtp_pkg::ST_DENIED;
        end else if (!free_found) begin
          status_next = owtp_pkg::ST_EXHAUSTED;
        end else begin
          value_next      = owtp_pkg::TIME_W'(free_idx);
          alloc_set       = 1'b1;
          wr_en           = 1'b1;
          wr_addr         = free_idx;
          wr_data         = '0;
          wr_data.owner   = owner_q;
        end
      end
      owtp_pkg::MODE_START, owtp_pkg::MODE_STOP, owtp_pkg::MODE_READ,
      owtp_pkg::MODE_FREE: begin
        if (!cap_q) begin
          status_next = owtp_pkg::ST_DENIED;
        end else begin
          status_next = chk_status;
          if (chk_ok) begin
            case (mode_q)
              owtp_pkg::MODE_START: begin
                wr_en           = 1'b1;
                wr_data.start   = uptime;
                wr_data.elapsed = '0;
                wr_data.running = 1'b1;
              end
              owtp_pkg::MODE_STOP: begin
                if (rd_q.running) begin
                  wr_en           = 1'b1;
                  wr_data.elapsed = live_elapsed;
                  wr_data.running = 1'b0;
                end
              end
              owtp_pkg::MODE_READ: begin
                value_next = rd_q.running ? live_elapsed : rd_q.elapsed;
              end
              default: begin
                alloc_clr = 1'b1;
              end
            endcase
          end
        end
      end
      default: begin
        status_next = owtp_pkg::ST_INVALID;
      end
    endcase
  end

  // Slot memory: one read port, one write port. A request is only accepted after the
  // previous write back has landed, so a read never overlaps a write to the same slot.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= mem[rd_addr];
    end
    if (state == S_EXEC && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= s_tdata[owtp_pkg::MODE_W-1:0];
      handle_q <= s_tdata[owtp_pkg::MODE_W +: owtp_pkg::HANDLE_W];
      owner_q  <= OWNER_BITS'(s_tdata[owtp_pkg::MODE_W + owtp_pkg::HANDLE_W +:
                                      owtp_pkg::OWNER_W]);
      cap_q    <= s_tuser[0];
    end
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      uptime   <= '0;
      alloc    <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state    <= S_IDLE;
          m_tvalid <= 1'b1;
          status_q <= status_next;
          value_q  <= value_next;
          if (tick) begin
            uptime <= uptime + 1'b1;
          end
          if (alloc_set) begin
            alloc[free_idx] <= 1'b1;
          end
          if (alloc_clr) begin
            alloc[idx] <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Every accepted request is followed by its result word once the execute state has run.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##1 m_tvalid)
    else $error("result word missing after accepted request");

  // A request is never taken while a result is stuck in the output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("request accepted while result is stalled");

  // No two requests in consecutive cycles.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request accepted during execute");

  // A successful create returns a handle inside the pool.
  a_create_handle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && mode_q == owtp_pkg::MODE_CREATE &&
     status_next == owtp_pkg::ST_OK) |-> (value_next < owtp_pkg::TIME_W'(SLOTS)))
    else $error("create returned a handle outside the pool");
`endif

endmodule

`default_nettype wire
